// ===== src/lqws_pkg.sv =====
// Shared types and constants for the link quality window statistics block.
// No dependencies.
package lqws_pkg;

    // Quotient register width of the shared divider (covers successes << 16)
    localparam int DIV_W = 48;
    // Divisor and remainder width of the shared divider
    localparam int DSR_W = 32;

    // Success rate of one in Q1.16, the saturation ceiling
    localparam logic [16:0] RATE_ONE = 17'd65536;
    // Mean RSSI reported when no delivered entry is in the window
    localparam logic signed [8:0] NO_SIGNAL_DBM = -9'sd120;

    // One history entry, 58 bits
    typedef struct packed {
        logic              delivered;
        logic signed [8:0] signal;
        logic signed [7:0] snr;
        logic [7:0]        retries;
        logic [31:0]       latency;
    } entry_t;

endpackage

// ===== src/link_quality_window_stats.sv =====
// Sliding-window link statistics: ring of recent reports, counters and means.
// Uses lqws_pkg for the entry type and divider constants.
//
//   channel | direction | beat contents
//   s_      | in        | action, delivered, signal_dbm, snr_quarter_db, retry_count, latency_ms
//   m_      | out       | counters, window_fill, delivery_ratio and four window means
//
// Each beat runs a walk over the filled ring entries, one read per cycle from the ring memory,
// then five divisions, one quotient bit per cycle, through a single shared restoring divider.
// s_ready is high only while idle; the result is held on m_ until m_ready takes it.
// Synchronous active-low reset empties the window and zeroes both counters.
module link_quality_window_stats #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_action,
    input  logic                                   s_delivered,
    input  logic signed [8:0]                      s_signal_dbm,
    input  logic signed [7:0]                      s_snr_quarter_db,
    input  logic [7:0]                             s_retry_count,
    input  logic [31:0]                            s_latency_ms,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [31:0]                            m_total_count,
    output logic [31:0]                            m_success_count,
    output logic [$clog2(WINDOW_DEPTH + 1) - 1:0]  m_window_fill,
    output logic [16:0]                            m_delivery_ratio,
    output logic signed [8:0]                      m_mean_signal_dbm,
    output logic signed [7:0]                      m_mean_snr_quarter_db,
    output logic [15:0]                            m_mean_retries_q8,
    output logic [31:0]                            m_mean_latency_ms
);
    import lqws_pkg::*;

    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SIG_SUM_W = 9 + CNT_W;
    localparam int SNR_SUM_W = 8 + CNT_W;
    localparam int RTY_SUM_W = 8 + CNT_W;
    localparam int LAT_SUM_W = 32 + CNT_W;
    localparam int STEP_W    = $clog2(DIV_W);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_STORE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // Division jobs, run in this order
    localparam logic [2:0] OP_RATE  = 3'd0;
    localparam logic [2:0] OP_SIG   = 3'd1;
    localparam logic [2:0] OP_SNR   = 3'd2;
    localparam logic [2:0] OP_RETRY = 3'd3;
    localparam logic [2:0] OP_LAT   = 3'd4;

    // Ring memory
    entry_t ring_mem [WINDOW_DEPTH];
    entry_t rd_data_reg;
    entry_t wr_entry;
    logic   wr_en;
    logic   rd_en;

    logic [2:0]                 state_reg, state_next;
    logic [2:0]                 op_reg, op_next;
    logic [31:0]                total_reg, total_next;
    logic [31:0]                succ_reg, succ_next;
    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic [IDX_W-1:0]           slot_reg, slot_next;
    logic [CNT_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic signed [SIG_SUM_W-1:0] sum_sig_reg, sum_sig_next;
    logic signed [SNR_SUM_W-1:0] sum_snr_reg, sum_snr_next;
    logic [RTY_SUM_W-1:0]       sum_rty_reg, sum_rty_next;
    logic [LAT_SUM_W-1:0]       sum_lat_reg, sum_lat_next;
    logic [CNT_W-1:0]           n_ok_reg, n_ok_next;
    logic [CNT_W-1:0]           n_lat_reg, n_lat_next;
    logic [DIV_W-1:0]           dvd_reg, dvd_next;
    logic [DSR_W-1:0]           dsr_reg, dsr_next;
    logic [DSR_W-1:0]           rem_reg, rem_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [16:0]                rate_reg, rate_next;
    logic signed [8:0]          msig_reg, msig_next;
    logic signed [7:0]          msnr_reg, msnr_next;
    logic [15:0]                mrty_reg, mrty_next;
    logic [31:0]                mlat_reg, mlat_next;

    logic [SIG_SUM_W-1:0]       sig_abs;
    logic [SNR_SUM_W-1:0]       snr_abs;
    logic [DSR_W:0]             trial;
    logic                       trial_ge;
    logic [8:0]                 sig_mag;
    logic [7:0]                 snr_mag;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    assign wr_en = s_valid && s_ready && !s_action;
    assign rd_en = (state_reg == ST_SCAN) && (rd_idx_reg < fill_reg);

    always_comb begin
        wr_entry.delivered = s_delivered;
        wr_entry.signal    = s_signal_dbm;
        wr_entry.snr       = s_snr_quarter_db;
        wr_entry.retries   = s_retry_count;
        wr_entry.latency   = s_latency_ms;
    end

    // Write one report, read one entry per cycle during the walk
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[slot_reg] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // Magnitudes of the signed sums and one restoring divider step
    assign sig_abs  = sum_sig_reg[SIG_SUM_W-1] ? SIG_SUM_W'(-sum_sig_reg) : sum_sig_reg;
    assign snr_abs  = sum_snr_reg[SNR_SUM_W-1] ? SNR_SUM_W'(-sum_snr_reg) : sum_snr_reg;
    assign trial    = {rem_reg, dvd_reg[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, dsr_reg});
    assign sig_mag  = dvd_reg[8:0];
    assign snr_mag  = dvd_reg[7:0];

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        total_next   = total_reg;
        succ_next    = succ_reg;
        fill_next    = fill_reg;
        slot_next    = slot_reg;
        rd_idx_next  = rd_idx_reg;
        rd_vld_next  = rd_vld_reg;
        sum_sig_next = sum_sig_reg;
        sum_snr_next = sum_snr_reg;
        sum_rty_next = sum_rty_reg;
        sum_lat_next = sum_lat_reg;
        n_ok_next    = n_ok_reg;
        n_lat_next   = n_lat_reg;
        dvd_next     = dvd_reg;
        dsr_next     = dsr_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        rate_next    = rate_reg;
        msig_next    = msig_reg;
        msnr_next    = msnr_reg;
        mrty_next    = mrty_reg;
        mlat_next    = mlat_reg;

        case (state_reg)
            ST_IDLE: begin
                // Take a beat: clear or record, then start the walk
                if (s_valid) begin
                    if (s_action) begin
                        total_next = '0;
                        succ_next  = '0;
                        fill_next  = '0;
                        slot_next  = '0;
                    end else begin
                        total_next = total_reg + 32'd1;
                        succ_next  = succ_reg + 32'(s_delivered);
                        slot_next  = (slot_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                             : slot_reg + 1'b1;
                        if (fill_reg < CNT_W'(WINDOW_DEPTH)) begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    rd_idx_next  = '0;
                    rd_vld_next  = 1'b0;
                    sum_sig_next = '0;
                    sum_snr_next = '0;
                    sum_rty_next = '0;
                    sum_lat_next = '0;
                    n_ok_next    = '0;
                    n_lat_next   = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Advance the read index and fold in the entry read last cycle
                rd_vld_next = rd_en;
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    sum_rty_next = sum_rty_reg + RTY_SUM_W'(rd_data_reg.retries);
                    if (rd_data_reg.delivered) begin
                        sum_sig_next = sum_sig_reg + SIG_SUM_W'(rd_data_reg.signal);
                        sum_snr_next = sum_snr_reg + SNR_SUM_W'(rd_data_reg.snr);
                        n_ok_next    = n_ok_reg + 1'b1;
                        if (rd_data_reg.latency != 32'd0) begin
                            sum_lat_next = sum_lat_reg + LAT_SUM_W'(rd_data_reg.latency);
                            n_lat_next   = n_lat_reg + 1'b1;
                        end
                    end
                end
                if (!rd_en && !rd_vld_reg) begin
                    op_next    = OP_RATE;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // Load dividend and divisor for the current job
                rem_next  = '0;
                step_next = '0;
                case (op_reg)
                    OP_RATE: begin
                        dvd_next = DIV_W'({succ_reg, 16'h0000});
                        dsr_next = total_reg;
                    end
                    OP_SIG: begin
                        dvd_next = DIV_W'(sig_abs);
                        dsr_next = DSR_W'(n_ok_reg);
                    end
                    OP_SNR: begin
                        dvd_next = DIV_W'(snr_abs);
                        dsr_next = DSR_W'(n_ok_reg);
                    end
                    OP_RETRY: begin
                        dvd_next = DIV_W'({sum_rty_reg, 8'h00});
                        dsr_next = DSR_W'(fill_reg);
                    end
                    default: begin
                        dvd_next = DIV_W'(sum_lat_reg);
                        dsr_next = DSR_W'(n_lat_reg);
                    end
                endcase
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // One quotient bit per cycle
                rem_next = trial_ge ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], trial_ge};
                if (step_reg == STEP_W'(DIV_W - 1)) begin
                    state_next = ST_STORE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_STORE: begin
                // Drop the quotient into its result, with the empty-set values
                case (op_reg)
                    OP_RATE: begin
                        if (total_reg == 32'd0) begin
                            rate_next = '0;
                        end else if (dvd_reg > DIV_W'(RATE_ONE)) begin
                            rate_next = RATE_ONE;
                        end else begin
                            rate_next = dvd_reg[16:0];
                        end
                    end
                    OP_SIG: begin
                        if (n_ok_reg == '0) begin
                            msig_next = NO_SIGNAL_DBM;
                        end else begin
                            msig_next = sum_sig_reg[SIG_SUM_W-1] ? 9'(-sig_mag) : sig_mag;
                        end
                    end
                    OP_SNR: begin
                        if (n_ok_reg == '0) begin
                            msnr_next = '0;
                        end else begin
                            msnr_next = sum_snr_reg[SNR_SUM_W-1] ? 8'(-snr_mag) : snr_mag;
                        end
                    end
                    OP_RETRY: begin
                        mrty_next = (fill_reg == '0) ? 16'd0 : dvd_reg[15:0];
                    end
                    default: begin
                        mlat_next = (n_lat_reg == '0) ? 32'd0 : dvd_reg[31:0];
                    end
                endcase
                if (op_reg == OP_LAT) begin
                    state_next = ST_OUT;
                end else begin
                    op_next    = op_reg + 3'd1;
                    state_next = ST_LOAD;
                end
            end
            ST_OUT: begin
                // Hold the result until it is taken
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_RATE;
            total_reg  <= '0;
            succ_reg   <= '0;
            fill_reg   <= '0;
            slot_reg   <= '0;
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            step_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            total_reg  <= total_next;
            succ_reg   <= succ_next;
            fill_reg   <= fill_next;
            slot_reg   <= slot_next;
            rd_idx_reg <= rd_idx_next;
            rd_vld_reg <= rd_vld_next;
            step_reg   <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        sum_sig_reg <= sum_sig_next;
        sum_snr_reg <= sum_snr_next;
        sum_rty_reg <= sum_rty_next;
        sum_lat_reg <= sum_lat_next;
        n_ok_reg    <= n_ok_next;
        n_lat_reg   <= n_lat_next;
        dvd_reg     <= dvd_next;
        dsr_reg     <= dsr_next;
        rem_reg     <= rem_next;
        rate_reg    <= rate_next;
        msig_reg    <= msig_next;
        msnr_reg    <= msnr_next;
        mrty_reg    <= mrty_next;
        mlat_reg    <= mlat_next;
    end

    assign m_total_count         = total_reg;
    assign m_success_count       = succ_reg;
    assign m_window_fill         = fill_reg;
    assign m_delivery_ratio      = rate_reg;
    assign m_mean_signal_dbm     = msig_reg;
    assign m_mean_snr_quarter_db = msnr_reg;
    assign m_mean_retries_q8     = mrty_reg;
    assign m_mean_latency_ms     = mlat_reg;

endmodule
